FILE: src/stid_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; imported by stid_cell, the top level and the text checker.
`timescale 1ns / 1ps

package stid_pkg;

    // Binary magnitude width and the number of BCD digit cells.
    localparam int MAG_W      = 32;
    localparam int NUM_CELLS  = 10;
    localparam int DIGIT_W    = 4;

    // Magnitude bits that enter the chain in one cycle.
    localparam int STEP_BITS  = 4;
    localparam int CONV_STEPS = MAG_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);
    localparam int IDX_W      = $clog2(NUM_CELLS);

    // ASCII codes.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // Control that every digit cell receives.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

FILE: src/stid_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion chain.
// Depends on stid_pkg for widths and the control struct.
`timescale 1ns / 1ps

module stid_cell
    import stid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [STEP_BITS-1:0] in_bits,
    output logic [STEP_BITS-1:0] out_bits,
    output digit_t               digit
);

    digit_t digit_reg;
    digit_t digit_next;

    // Apply STEP_BITS correct-then-shift steps, most significant bit first.
    always_comb
    begin
        digit_t work;
        digit_t fixed;
        work     = digit_reg;
        out_bits = '0;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            fixed = (work >= 4'd5) ? (work + 4'd3) : work;
            out_bits[STEP_BITS-1-j] = fixed[DIGIT_W-1];
            work = {fixed[DIGIT_W-2:0], in_bits[STEP_BITS-1-j]};
        end
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = work;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    // Digit storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

FILE: src/signed_int_to_decimal_ascii_unit.sv
// Top level: signed 32-bit integer to decimal ASCII text, one byte per character.
// Depends on stid_pkg and stid_cell.
//
//  Channel | Ports                          | Handshake
//  --------+--------------------------------+------------------------------
//  input   | value[31:0]                    | start high while busy low
//  output  | text_byte[7:0], last_char      | valid, one cycle, no stall
//
// An item passes through a load step, conversion through the 10-cell BCD
// chain (4 magnitude bits per cycle), a leading-digit scan, then the serial
// character output. busy stays high from the accepting edge until the last
// character is issued. Reset is asynchronous, active low, and returns the
// unit to idle. The receiver cannot stall; each character is shown once.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit
    import stid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    output logic        valid,
    output logic [7:0]  text_byte,
    output logic        last_char
);

    state_t                 state_reg, state_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;

    cell_ctrl_t             ctrl;
    logic [STEP_BITS-1:0]   chain_bits [NUM_CELLS+1];
    digit_t                 digits [NUM_CELLS];
    logic [IDX_W-1:0]       lead_idx;
    digit_t                 sel_digit;
    logic                   accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Row of digit cells; the magnitude feeds the lowest cell.
    assign chain_bits[0] = mag_reg[MAG_W-1 -: STEP_BITS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        stid_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .in_bits  (chain_bits[i]),
            .out_bits (chain_bits[i+1]),
            .digit    (digits[i])
        );
    end

    // Highest nonzero digit; zero renders as the lowest digit alone.
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (digits[i] != '0)
            begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    assign sel_digit = digits[ptr_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (step_reg == STEP_CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output control.
    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        ptr_next   = ptr_reg;
        valid_next = 1'b0;
        byte_next  = byte_reg;
        last_next  = last_reg;
        ctrl.clear = 1'b0;
        ctrl.shift = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[MAG_W-1];
                    mag_next   = value[MAG_W-1] ? (~value + 32'd1) : value;
                    step_next  = '0;
                    ctrl.clear = 1'b1;
                end
            end
            ST_CONV:
            begin
                ctrl.shift = 1'b1;
                mag_next   = {mag_reg[MAG_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                step_next  = step_reg + 1'b1;
            end
            ST_SCAN:
            begin
                ptr_next = lead_idx;
            end
            ST_SIGN:
            begin
                valid_next = 1'b1;
                byte_next  = CHAR_MINUS;
                last_next  = 1'b0;
            end
            ST_DIGITS:
            begin
                valid_next = 1'b1;
                byte_next  = CHAR_ZERO + {4'd0, sel_digit};
                last_next  = (ptr_reg == '0);
                ptr_next   = ptr_reg - 1'b1;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            step_reg  <= step_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign text_byte = byte_reg;
    assign last_char = last_reg;

    // An accepted item makes the unit busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting an item");

    // A character only leaves while an item is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("character issued with no item in work");

    // The final character of a number is always a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last_char) |-> (text_byte >= CHAR_ZERO && text_byte <= 8'd57))
        else $error("final character is not a digit");

    // A minus sign is followed by a digit in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && text_byte == CHAR_MINUS) |=> (valid && text_byte != CHAR_MINUS))
        else $error("minus sign not followed by a digit");

endmodule

FILE: tb/sv/stid_text_checker.sv
// Checker for the signed integer to decimal ASCII unit: predicts the text of every
// accepted item and compares each output character against it. Depends on stid_pkg.
`timescale 1ns / 1ps

module stid_text_checker
    import stid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] value,
    input  logic        valid,
    input  logic [7:0]  text_byte,
    input  logic        last_char,
    output int          errors,
    output int          pending
);

    // One character of expected text.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];
    text_char_t oldest;
    int         mismatch_count = 0;

    assign errors = mismatch_count;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Queue the decimal text of one number: sign first, then digits from the most
    // significant one, with leading zeros suppressed.
    function automatic void predict_decimal_text(input logic [31:0] number);
        logic [7:0]  digit_chars[NUM_CELLS];
        logic [31:0] magnitude;
        int          count;
        text_char_t  entry;

        // The most negative value wraps to its own magnitude in unsigned arithmetic.
        magnitude = number[31] ? (32'd0 - number) : number;
        count     = 0;
        do
        begin
            digit_chars[count] = CHAR_ZERO + 8'(magnitude % 32'd10);
            magnitude          = magnitude / 32'd10;
            count++;
        end
        while (magnitude != 0 && count < NUM_CELLS);

        if (number[31])
        begin
            entry.char_code = CHAR_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            entry.char_code = digit_chars[k];
            entry.last      = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    // Watch both channels at every rising edge once reset is released.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_decimal_text(value);
            end
            if (valid)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("character %0d with no item pending",
                                              text_byte));
                end
                else
                begin
                    oldest = expected_text.pop_front();
                    if (text_byte !== oldest.char_code || last_char !== oldest.last)
                    begin
                        report_mismatch($sformatf(
                            "text_byte %0d last_char %b, expected %0d last_char %b",
                            text_byte, last_char, oldest.char_code, oldest.last));
                    end
                end
            end
            pending <= expected_text.size();
        end
    end

endmodule

FILE: tb/sv/signed_int_to_decimal_ascii_unit_tb.sv
// Testbench top for the signed integer to decimal ASCII unit: drives numbers back to back
// and with random gaps and gives the verdict. Depends on stid_pkg, the unit and stid_text_checker.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 380;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] value;
    logic        valid;
    logic [7:0]  text_byte;
    logic        last_char;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    logic        steady_run  = 1'b0;

    signed_int_to_decimal_ascii_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .valid     (valid),
        .text_byte (text_byte),
        .last_char (last_char)
    );

    stid_text_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .valid     (valid),
        .text_byte (text_byte),
        .last_char (last_char),
        .errors    (errors),
        .pending   (pending)
    );

    // Free-running clock with an 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Guard against a hung unit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one number and hold it until the unit takes it. Start stays high
    // across back-to-back items so that it is never dropped and raised in one step.
    task automatic send_number(input logic [31:0] number);
        int gap;

        gap = steady_run ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= number;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
    endtask

    // Stop offering items until every expected character has come out.
    task automatic drain_text();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    // Draw a number: full random words, values of a chosen digit count,
    // values around a power of ten, and small values near zero.
    function automatic logic [31:0] draw_number();
        longint      magnitude;
        longint      low_mag;
        longint      high_mag;
        logic [63:0] span;
        logic [63:0] noise;
        int          digits;
        int          kind;
        logic        negative;

        kind     = $urandom_range(0, 9);
        negative = 1'($urandom_range(0, 1));
        if (kind <= 2)
        begin
            return $urandom;
        end
        if (kind <= 7)
        begin
            digits  = $urandom_range(1, 10);
            low_mag = 1;
            repeat (digits - 1) low_mag *= 10;
            high_mag = low_mag * 10 - 1;
            if (digits == 1)
            begin
                low_mag = 0;
            end
            if (high_mag > 64'd2147483648)
            begin
                high_mag = 64'd2147483648;
            end
            span      = high_mag - low_mag + 1;
            noise     = {$urandom, $urandom};
            magnitude = low_mag + longint'(noise % span);
        end
        else if (kind == 8)
        begin
            magnitude = 1;
            repeat ($urandom_range(1, 9)) magnitude *= 10;
            magnitude = magnitude + longint'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            magnitude = longint'($urandom_range(0, 20));
        end
        if (!negative && magnitude > 64'd2147483647)
        begin
            magnitude = 64'd2147483647;
        end
        return negative ? 32'(-magnitude) : 32'(magnitude);
    endfunction

    // Reset, directed numbers, then random numbers, then the verdict.
    initial
    begin
        logic [31:0] directed_numbers[$] = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
            32'h0000_000A, 32'hFFFF_FFF6, 32'hFFFF_FFF7, 32'h0000_0063,
            32'h0000_0064, 32'h0000_3039, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
            32'h8000_0000, 32'h8000_0001, 32'h3B9A_C9FF, 32'h3B9A_CA00,
            32'hC465_3600, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000
        };

        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: first half back to back, second half with random gaps.
        steady_run = 1'b1;
        for (int i = 0; i < directed_numbers.size(); i++)
        begin
            if (i == directed_numbers.size() / 2)
            begin
                steady_run = 1'b0;
            end
            send_number(directed_numbers[i]);
        end
        drain_text();

        // Random part, in stretches that are drawn at random with or without idle gaps.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
            begin
                steady_run = ($urandom_range(0, 3) == 0);
            end
            if (i % 60 == 59)
            begin
                drain_text();
            end
            send_number(draw_number());
        end

        drain_text();
        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
